### sv/fpq_pkg.sv
// Shared types and constants for the five-level priority queue.
// No dependencies; used by fpq_cell, fpq_chain and the top level.
package fpq_pkg;

  // Table size and field widths
  localparam int CAPACITY   = 64;
  localparam int NUM_LEVELS = 5;
  localparam int ID_W       = 16;
  localparam int LVL_W      = 3;
  localparam int ACT_W      = 2;
  localparam int STS_W      = 2;
  localparam int OUT_W      = 7;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Reported counts saturate here
  localparam logic [OUT_W-1:0] COUNT_MAX = {OUT_W{1'b1}};

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NOP    = 2'd3
  } act_e;

  typedef enum logic [STS_W-1:0] {
    STS_DONE      = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SWEEP = 2'd1,
    S_DONE  = 2'd2
  } state_e;

  // One stored entry
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LVL_W-1:0] level;
  } entry_t;

  // Controls broadcast from the sequencer to every cell
  typedef struct packed {
    logic   add_en;     // append new_entry at the tail
    logic   shift_en;   // rotate one step: all move left, head re-enters at tail
    logic   keep_head;  // head re-enters (clear: head is dropped)
    entry_t new_entry;
  } chain_ctrl_t;

  // Status returned by the chain
  typedef struct packed {
    entry_t head;
    logic   full;
  } chain_stat_t;

endpackage

### sv/fpq_cell.sv
// One slot of the entry chain: holds an entry and its valid bit.
// Depends on fpq_pkg.
module fpq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fpq_pkg::chain_ctrl_t ctrl_i,
  input  logic                left_valid_i,
  input  logic                right_valid_i,
  input  fpq_pkg::entry_t     right_entry_i,
  input  fpq_pkg::entry_t     head_i,
  output logic                valid_o,
  output fpq_pkg::entry_t     entry_o
);

  logic            valid_q, valid_d;
  fpq_pkg::entry_t entry_q, entry_d;
  logic            load;

  // Next slot contents: append, rotate step or hold
  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    load    = 1'b0;
    if (ctrl_i.add_en) begin
      // first empty slot takes the new entry
      if (left_valid_i && !valid_q) begin
        valid_d = 1'b1;
        entry_d = ctrl_i.new_entry;
        load    = 1'b1;
      end
    end else if (ctrl_i.shift_en) begin
      // last occupied slot becomes the new tail for the head entry
      if (valid_q && !right_valid_i && ctrl_i.keep_head) begin
        valid_d = 1'b1;
        entry_d = head_i;
      end else begin
        valid_d = right_valid_i;
        entry_d = right_entry_i;
      end
      load = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      entry_q <= entry_d;
    end
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

### sv/fpq_chain.sv
// Row of fpq_cell slots linked to their neighbors; slot 0 is the head.
// Depends on fpq_pkg and fpq_cell.
module fpq_chain (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fpq_pkg::chain_ctrl_t ctrl_i,
  output fpq_pkg::chain_stat_t stat_o
);

  logic            valid [fpq_pkg::CAPACITY];
  fpq_pkg::entry_t entry [fpq_pkg::CAPACITY];

  for (genvar i = 0; i < fpq_pkg::CAPACITY; i++) begin : g_cell
    logic            left_valid;
    logic            right_valid;
    fpq_pkg::entry_t right_entry;

    // neighbor links, with fixed values at both ends
    if (i == 0) begin : g_first
      assign left_valid = 1'b1;
    end else begin : g_left
      assign left_valid = valid[i-1];
    end
    if (i == fpq_pkg::CAPACITY - 1) begin : g_last
      assign right_valid = 1'b0;
      assign right_entry = '0;
    end else begin : g_right
      assign right_valid = valid[i+1];
      assign right_entry = entry[i+1];
    end

    fpq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl_i),
      .left_valid_i  (left_valid),
      .right_valid_i (right_valid),
      .right_entry_i (right_entry),
      .head_i        (entry[0]),
      .valid_o       (valid[i]),
      .entry_o       (entry[i])
    );
  end

  assign stat_o.head = entry[0];
  assign stat_o.full = valid[fpq_pkg::CAPACITY-1];

endmodule

### sv/five_level_priority_fifo_with_removal.sv
// Five-level priority queue table with removal by id. Entries sit in a chain of
// CAPACITY slots in arrival order. An add goes straight to the result state and
// frees the input once its result is loaded into the output register. Remove
// and query rotate the whole chain once through its head slot, one entry per
// cycle, before the result state; on an empty table the rotation is skipped.
// One item is worked at a time; a finished result waits in the output register
// while the next item is already taken in, and while that register stays
// stalled the next finished item holds the input.
// Depends on fpq_pkg and fpq_chain.
module five_level_priority_fifo_with_removal (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // item channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [fpq_pkg::ACT_W-1:0]  action_i,
  input  logic [fpq_pkg::ID_W-1:0]   entry_id_i,
  input  logic [fpq_pkg::LVL_W-1:0]  level_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [fpq_pkg::STS_W-1:0]  status_o,
  output logic [fpq_pkg::OUT_W-1:0]  ahead_red_o,
  output logic [fpq_pkg::OUT_W-1:0]  ahead_orange_o,
  output logic [fpq_pkg::OUT_W-1:0]  ahead_yellow_o,
  output logic [fpq_pkg::OUT_W-1:0]  ahead_green_o,
  output logic [fpq_pkg::OUT_W-1:0]  ahead_blue_o
);

  localparam int NL = fpq_pkg::NUM_LEVELS;
  localparam logic [fpq_pkg::CNT_W-1:0] FILL_FULL = fpq_pkg::CNT_W'(fpq_pkg::CAPACITY);

  fpq_pkg::state_e  state_q, state_d;
  fpq_pkg::act_e    act_q, act_d;
  fpq_pkg::status_e sts_q, sts_d;
  fpq_pkg::status_e status_q, status_d;
  logic [fpq_pkg::ID_W-1:0]  key_q, key_d;
  logic [fpq_pkg::CNT_W-1:0] rem_q, rem_d;
  logic [fpq_pkg::CNT_W-1:0] fill_q, fill_d;
  logic [NL-1:0]             taken_q, taken_d;
  logic [fpq_pkg::OUT_W-1:0] cnt_q   [NL];
  logic [fpq_pkg::OUT_W-1:0] cnt_d   [NL];
  logic [fpq_pkg::OUT_W-1:0] ahead_q [NL];
  logic [fpq_pkg::OUT_W-1:0] ahead_d [NL];
  logic                      out_valid_q, out_valid_d;

  fpq_pkg::chain_ctrl_t ctrl;
  fpq_pkg::chain_stat_t stat;

  fpq_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

  assign in_stall_o = (state_q != fpq_pkg::S_IDLE);

  // Sequencer: next state, chain controls and result assembly
  always_comb begin
    logic hit;
    logic seen;
    state_d     = state_q;
    act_d       = act_q;
    key_d       = key_q;
    rem_d       = rem_q;
    fill_d      = fill_q;
    taken_d     = taken_q;
    cnt_d       = cnt_q;
    sts_d       = sts_q;
    status_d    = status_q;
    ahead_d     = ahead_q;
    out_valid_d = out_valid_q && out_stall_i;
    ctrl        = '0;
    ctrl.new_entry.id    = entry_id_i;
    ctrl.new_entry.level = level_i;
    hit  = 1'b0;
    seen = 1'b0;

    case (state_q)
      fpq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          act_d   = fpq_pkg::act_e'(action_i);
          key_d   = entry_id_i;
          taken_d = '0;
          rem_d   = fill_q;
          sts_d   = fpq_pkg::STS_DONE;
          for (int c = 0; c < NL; c++) begin
            cnt_d[c] = '0;
          end
          case (fpq_pkg::act_e'(action_i))
            fpq_pkg::ACT_ADD: begin
              // out-of-range class is ignored
              if (level_i < fpq_pkg::LVL_W'(NL)) begin
                if (fill_q == FILL_FULL) begin
                  sts_d = fpq_pkg::STS_FULL;
                end else begin
                  ctrl.add_en = 1'b1;
                  fill_d      = fill_q + fpq_pkg::CNT_W'(1);
                end
              end
              state_d = fpq_pkg::S_DONE;
            end
            fpq_pkg::ACT_REMOVE, fpq_pkg::ACT_QUERY: begin
              state_d = (fill_q == '0) ? fpq_pkg::S_DONE : fpq_pkg::S_SWEEP;
            end
            default: begin
              state_d = fpq_pkg::S_DONE;
            end
          endcase
        end
      end

      fpq_pkg::S_SWEEP: begin
        // inspect the head entry, then rotate it to the tail or drop it
        for (int c = 0; c < NL; c++) begin
          if (stat.head.level == fpq_pkg::LVL_W'(c)) begin
            seen = taken_q[c];
          end
        end
        hit = (stat.head.id == key_q) && (stat.head.level < fpq_pkg::LVL_W'(NL)) && !seen;
        ctrl.shift_en  = 1'b1;
        ctrl.keep_head = !((act_q == fpq_pkg::ACT_REMOVE) && hit);
        for (int c = 0; c < NL; c++) begin
          if (stat.head.level == fpq_pkg::LVL_W'(c)) begin
            if (hit) begin
              taken_d[c] = 1'b1;
            end else if ((act_q == fpq_pkg::ACT_QUERY) && !taken_q[c] &&
                         (cnt_q[c] != fpq_pkg::COUNT_MAX)) begin
              cnt_d[c] = cnt_q[c] + fpq_pkg::OUT_W'(1);
            end
          end
        end
        if ((act_q == fpq_pkg::ACT_REMOVE) && hit) begin
          fill_d = fill_q - fpq_pkg::CNT_W'(1);
        end
        rem_d = rem_q - fpq_pkg::CNT_W'(1);
        if (rem_q == fpq_pkg::CNT_W'(1)) begin
          state_d = fpq_pkg::S_DONE;
        end
      end

      fpq_pkg::S_DONE: begin
        // load the result once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          case (act_q)
            fpq_pkg::ACT_REMOVE, fpq_pkg::ACT_QUERY: begin
              status_d = (|taken_q) ? fpq_pkg::STS_DONE : fpq_pkg::STS_NOT_FOUND;
            end
            default: begin
              status_d = sts_q;
            end
          endcase
          // on a query, classes up to the holding one report, later ones report zero; other actions report zero
          for (int c = 0; c < NL; c++) begin
            ahead_d[c] = ((act_q == fpq_pkg::ACT_QUERY) && !seen) ? cnt_q[c] : '0;
            seen       = seen | taken_q[c];
          end
          state_d = fpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = fpq_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fpq_pkg::S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    key_q    <= key_d;
    rem_q    <= rem_d;
    taken_q  <= taken_d;
    cnt_q    <= cnt_d;
    sts_q    <= sts_d;
    status_q <= status_d;
    ahead_q  <= ahead_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign ahead_red_o    = ahead_q[0];
  assign ahead_orange_o = ahead_q[1];
  assign ahead_yellow_o = ahead_q[2];
  assign ahead_green_o  = ahead_q[3];
  assign ahead_blue_o   = ahead_q[4];

  // Fill count never passes the table size
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_FULL)
    else $error("fill count above capacity");

  // Between items the last slot is occupied exactly when the table is full
  a_full_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpq_pkg::S_IDLE) |-> (stat.full == (fill_q == FILL_FULL)))
    else $error("chain occupancy disagrees with fill count");

  // A rotation never runs with nothing left to visit
  a_sweep_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpq_pkg::S_SWEEP) |-> (rem_q != '0))
    else $error("rotation with no entries left");

  // A new result only appears out of the result state
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == fpq_pkg::S_DONE))
    else $error("result loaded outside result state");

endmodule

### bench/five_level_priority_fifo_with_removal_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the five-level priority queue table: directed rows,
// a fill-to-capacity pass and a long random run, scored against a table model or, for typed rows, a given outcome.
// Depends on fpq_pkg and five_level_priority_fifo_with_removal.
module five_level_priority_fifo_with_removal_tb;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = fpq_pkg::CAPACITY + 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 600;
  localparam logic [fpq_pkg::ID_W-1:0] ID_POOL_BASE = 16'h00A0;
  localparam logic [fpq_pkg::ID_W-1:0] ID_FILL_BASE = 16'h0100;

  // One result as the block reports it; ahead[0] is red, ahead[4] is blue
  typedef struct packed {
    fpq_pkg::status_e                                 status;
    logic [fpq_pkg::NUM_LEVELS-1:0][fpq_pkg::OUT_W-1:0] ahead;
  } outcome_t;

  typedef struct {
    fpq_pkg::act_e             act;
    logic [fpq_pkg::ID_W-1:0]  id;
    logic [fpq_pkg::LVL_W-1:0] lvl;
    bit                        typed;
    outcome_t                  want;
  } probe_row_t;

  logic                                               clk_i;
  logic                                               rst_ni;
  logic                                               in_valid_i;
  logic                                               in_stall_o;
  logic [fpq_pkg::ACT_W-1:0]                          action_i;
  logic [fpq_pkg::ID_W-1:0]                           entry_id_i;
  logic [fpq_pkg::LVL_W-1:0]                          level_i;
  logic                                               out_valid_o;
  logic                                               out_stall_i;
  logic [fpq_pkg::STS_W-1:0]                          status_o;
  logic [fpq_pkg::OUT_W-1:0]                          ahead_red_o;
  logic [fpq_pkg::OUT_W-1:0]                          ahead_orange_o;
  logic [fpq_pkg::OUT_W-1:0]                          ahead_yellow_o;
  logic [fpq_pkg::OUT_W-1:0]                          ahead_green_o;
  logic [fpq_pkg::OUT_W-1:0]                          ahead_blue_o;
  logic [fpq_pkg::NUM_LEVELS-1:0][fpq_pkg::OUT_W-1:0] seen_ahead;

  // Table model: entries in arrival order, slots below tbl_fill are live
  logic [fpq_pkg::ID_W-1:0]  tbl_id [fpq_pkg::CAPACITY];
  logic [fpq_pkg::LVL_W-1:0] tbl_level [fpq_pkg::CAPACITY];
  int                        tbl_fill = 0;

  outcome_t   awaited_outcomes[$];
  outcome_t   oldest;
  probe_row_t probe_rows[$];
  int         mismatches   = 0;
  int         results_seen = 0;
  int         cycle_count  = 0;
  bit         steady       = 1'b0;
  bit         hold_req     = 1'b0;

  five_level_priority_fifo_with_removal DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .entry_id_i     (entry_id_i),
    .level_i        (level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .ahead_red_o    (ahead_red_o),
    .ahead_orange_o (ahead_orange_o),
    .ahead_yellow_o (ahead_yellow_o),
    .ahead_green_o  (ahead_green_o),
    .ahead_blue_o   (ahead_blue_o)
  );

  assign seen_ahead = {ahead_blue_o, ahead_green_o, ahead_yellow_o, ahead_orange_o,
                       ahead_red_o};

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Apply one item to the table model and return the result it must produce
  function automatic outcome_t step_table(fpq_pkg::act_e act, logic [fpq_pkg::ID_W-1:0] id,
                                          logic [fpq_pkg::LVL_W-1:0] lvl);
    outcome_t res;
    bit       taken [fpq_pkg::NUM_LEVELS];
    bit       hit;
    int       kept;
    int       n;
    res.status = fpq_pkg::STS_DONE;
    res.ahead  = '0;
    hit        = 1'b0;
    kept       = 0;
    foreach (taken[c]) taken[c] = 1'b0;
    case (act)
      fpq_pkg::ACT_ADD: begin
        // out-of-range class is ignored without a flag
        if (lvl < fpq_pkg::NUM_LEVELS) begin
          if (tbl_fill >= fpq_pkg::CAPACITY) begin
            res.status = fpq_pkg::STS_FULL;
          end else begin
            tbl_id[tbl_fill]    = id;
            tbl_level[tbl_fill] = lvl;
            tbl_fill++;
          end
        end
      end
      fpq_pkg::ACT_REMOVE: begin
        // first match per class drops out, the rest closes up
        for (int i = 0; i < tbl_fill; i++) begin
          if (!taken[tbl_level[i]] && tbl_id[i] == id) begin
            taken[tbl_level[i]] = 1'b1;
            hit = 1'b1;
          end else begin
            tbl_id[kept]    = tbl_id[i];
            tbl_level[kept] = tbl_level[i];
            kept++;
          end
        end
        tbl_fill = kept;
        if (!hit) res.status = fpq_pkg::STS_NOT_FOUND;
      end
      fpq_pkg::ACT_QUERY: begin
        // full counts until the holding class, partial count there, zero after
        for (int c = 0; c < fpq_pkg::NUM_LEVELS && !hit; c++) begin
          n = 0;
          for (int i = 0; i < tbl_fill && !hit; i++) begin
            if (tbl_level[i] == c) begin
              if (tbl_id[i] == id) hit = 1'b1;
              else n++;
            end
          end
          res.ahead[c] = (n > int'(fpq_pkg::COUNT_MAX)) ? fpq_pkg::COUNT_MAX
                                                         : fpq_pkg::OUT_W'(n);
        end
        if (!hit) res.status = fpq_pkg::STS_NOT_FOUND;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic flag_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Offer one item, hold it through stalls, log the expectation on transfer
  task automatic issue(fpq_pkg::act_e act, logic [fpq_pkg::ID_W-1:0] id,
                       logic [fpq_pkg::LVL_W-1:0] lvl,
                       bit typed = 1'b0, outcome_t given = '0);
    outcome_t want;
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 16) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    action_i   = act;
    entry_id_i = id;
    level_i    = lvl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    want = step_table(act, id, lvl);
    awaited_outcomes.push_back(typed ? given : want);
  endtask

  // Stop sending until every result is in, then let the block go quiet
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_row(fpq_pkg::act_e act, logic [fpq_pkg::ID_W-1:0] id,
                         logic [fpq_pkg::LVL_W-1:0] lvl,
                         bit typed = 1'b0, fpq_pkg::status_e sts = fpq_pkg::STS_DONE);
    probe_row_t row;
    row.act         = act;
    row.id          = id;
    row.lvl         = lvl;
    row.typed       = typed;
    row.want.status = sts;
    row.want.ahead  = '0;
    probe_rows.push_back(row);
  endtask

  // Mostly ids from a small pool so duplicates and hits are common
  function automatic logic [fpq_pkg::ID_W-1:0] pick_id(bit prefer_held);
    if (prefer_held && tbl_fill > 0 && $urandom_range(99) < 70)
      return tbl_id[$urandom_range(tbl_fill - 1)];
    if ($urandom_range(99) < 60)
      return ID_POOL_BASE + fpq_pkg::ID_W'($urandom_range(15));
    return fpq_pkg::ID_W'($urandom_range(16'hFFFF));
  endfunction

  function automatic logic [fpq_pkg::LVL_W-1:0] pick_level();
    if ($urandom_range(99) < 94)
      return fpq_pkg::LVL_W'($urandom_range(fpq_pkg::NUM_LEVELS - 1));
    return fpq_pkg::LVL_W'($urandom_range(7, fpq_pkg::NUM_LEVELS));
  endfunction

  // Result side: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = !steady && ($urandom_range(99) < 16);
      end
    end
  end

  // Score each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      results_seen++;
      if (awaited_outcomes.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with none awaited", results_seen));
      end else begin
        oldest = awaited_outcomes.pop_front();
        if (status_o !== oldest.status)
          flag_mismatch($sformatf("result %0d status got %0d, expected %0d",
                                  results_seen, status_o, oldest.status));
        for (int c = 0; c < fpq_pkg::NUM_LEVELS; c++) begin
          if (seen_ahead[c] !== oldest.ahead[c])
            flag_mismatch($sformatf("result %0d ahead class %0d got %0d, expected %0d",
                                    results_seen, c, seen_ahead[c], oldest.ahead[c]));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int fill_goal;
    int roll;
    int add_pct;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    action_i   = fpq_pkg::ACT_ADD;
    entry_id_i = '0;
    level_i    = '0;
    fill_goal  = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows: empty table, extremes, ignored classes, duplicates, no-op
    add_row(fpq_pkg::ACT_QUERY,  16'h0000, 3'd0, 1'b1, fpq_pkg::STS_NOT_FOUND);
    add_row(fpq_pkg::ACT_REMOVE, 16'hFFFF, 3'd7, 1'b1, fpq_pkg::STS_NOT_FOUND);
    add_row(fpq_pkg::ACT_ADD,    16'h0000, 3'd0, 1'b1, fpq_pkg::STS_DONE);
    add_row(fpq_pkg::ACT_ADD,    16'hFFFF, 3'd4, 1'b1, fpq_pkg::STS_DONE);
    add_row(fpq_pkg::ACT_ADD,    16'h1234, 3'd2);
    add_row(fpq_pkg::ACT_ADD,    16'h1234, 3'd2);
    add_row(fpq_pkg::ACT_ADD,    16'h5555, 3'd1);
    add_row(fpq_pkg::ACT_ADD,    16'hAAAA, 3'd3);
    add_row(fpq_pkg::ACT_ADD,    16'h0001, 3'd5, 1'b1, fpq_pkg::STS_DONE);
    add_row(fpq_pkg::ACT_ADD,    16'h0002, 3'd7, 1'b1, fpq_pkg::STS_DONE);
    add_row(fpq_pkg::ACT_QUERY,  16'hFFFF, 3'd0);
    add_row(fpq_pkg::ACT_QUERY,  16'h1234, 3'd0);
    add_row(fpq_pkg::ACT_QUERY,  16'h0000, 3'd0);
    add_row(fpq_pkg::ACT_QUERY,  16'hBEEF, 3'd0);
    add_row(fpq_pkg::ACT_QUERY,  16'h0001, 3'd0);
    add_row(fpq_pkg::ACT_NOP,    16'hFFFF, 3'd7, 1'b1, fpq_pkg::STS_DONE);
    add_row(fpq_pkg::ACT_REMOVE, 16'h1234, 3'd0);
    add_row(fpq_pkg::ACT_QUERY,  16'h1234, 3'd0);
    add_row(fpq_pkg::ACT_ADD,    16'h1234, 3'd0);
    add_row(fpq_pkg::ACT_REMOVE, 16'h1234, 3'd3);
    add_row(fpq_pkg::ACT_QUERY,  16'h1234, 3'd0);
    add_row(fpq_pkg::ACT_REMOVE, 16'h7777, 3'd0, 1'b1, fpq_pkg::STS_NOT_FOUND);
    foreach (probe_rows[r])
      issue(probe_rows[r].act, probe_rows[r].id, probe_rows[r].lvl,
            probe_rows[r].typed, probe_rows[r].want);
    settle();

    // Fill every slot in the lowest class while the result side holds off
    while (tbl_fill > 0) issue(fpq_pkg::ACT_REMOVE, tbl_id[0], 3'd0);
    hold_req = 1'b1;
    for (int i = 0; i < fpq_pkg::CAPACITY + 2; i++)
      issue(fpq_pkg::ACT_ADD, ID_FILL_BASE + fpq_pkg::ID_W'(i), 3'd4);
    issue(fpq_pkg::ACT_QUERY, 16'hBEEF, 3'd0);
    issue(fpq_pkg::ACT_QUERY, ID_FILL_BASE + fpq_pkg::ID_W'(fpq_pkg::CAPACITY - 1), 3'd0);
    issue(fpq_pkg::ACT_QUERY, ID_FILL_BASE, 3'd0);
    while (tbl_fill > 0) issue(fpq_pkg::ACT_REMOVE, tbl_id[tbl_fill - 1], pick_level());

    // Random run, fill level steered toward goals that include empty and full
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 60 == 0) begin
        case ($urandom_range(2))
          0:       fill_goal = 0;
          1:       fill_goal = fpq_pkg::CAPACITY;
          default: fill_goal = $urandom_range(fpq_pkg::CAPACITY);
        endcase
      end
      steady = (k >= 300 && k < 400);
      if (k == 400) settle();
      if (k == 550) hold_req = 1'b1;
      roll    = $urandom_range(99);
      add_pct = (tbl_fill < fill_goal) ? 70 : 25;
      if (roll < 3)
        issue(fpq_pkg::ACT_NOP, fpq_pkg::ID_W'($urandom_range(16'hFFFF)),
              fpq_pkg::LVL_W'($urandom_range(7)));
      else if (roll < 3 + add_pct)
        issue(fpq_pkg::ACT_ADD, pick_id($urandom_range(3) == 0), pick_level());
      else if (roll < 3 + add_pct + (97 - add_pct) / 2)
        issue(fpq_pkg::ACT_REMOVE, pick_id(1'b1), fpq_pkg::LVL_W'($urandom_range(7)));
      else
        issue(fpq_pkg::ACT_QUERY, pick_id(1'b1), fpq_pkg::LVL_W'($urandom_range(7)));
    end
    steady = 1'b0;
    settle();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
sv/fpq_pkg.sv
sv/fpq_cell.sv
sv/fpq_chain.sv
sv/five_level_priority_fifo_with_removal.sv
bench/five_level_priority_fifo_with_removal_tb.sv
